[rtl/slx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_pkg - shared types and tables for the script lexer
// Token and bundle formats, token kind codes, keyword matching.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int KW_MAX_LEN_DEF  = 6;
  localparam int BUNDLE_TOKENS   = 4;

  localparam logic [5:0] K_DOT      = 6'd5;
  localparam logic [5:0] K_SLASH    = 6'd9;
  localparam logic [5:0] K_BANG     = 6'd11;
  localparam logic [5:0] K_EQUAL    = 6'd13;
  localparam logic [5:0] K_GREATER  = 6'd15;
  localparam logic [5:0] K_LESS     = 6'd17;
  localparam logic [5:0] K_IDENT    = 6'd19;
  localparam logic [5:0] K_NUMBER   = 6'd20;
  localparam logic [5:0] K_KEYWORD0 = 6'd21;
  localparam logic [5:0] K_ERROR    = 6'd37;
  localparam logic [5:0] K_END      = 6'd38;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
  } tok_t;

  // all tokens caused by one source byte, in emission order
  typedef struct packed {
    tok_t [BUNDLE_TOKENS-1:0] tok;
    logic [2:0]               cnt;
  } bundle_t;

  localparam logic [63:0] KW_PACK [16] = '{
    64'h616E64, 64'h636C617373, 64'h656C7365, 64'h66616C7365,
    64'h66756E, 64'h666F72, 64'h6966, 64'h6E696C,
    64'h6F72, 64'h7072696E74, 64'h72657475726E, 64'h7375706572,
    64'h74686973, 64'h74727565, 64'h766172, 64'h7768696C65};
  localparam logic [3:0] KW_LEN [16] = '{
    4'd3, 4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2, 4'd3,
    4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5};

  function automatic logic [5:0] kw_kind(input logic [63:0] pre, input logic [3:0] len);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      if (len == KW_LEN[i] && pre == KW_PACK[i]) k = K_KEYWORD0 + 6'(i);
    end
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c);
    case (c)
      "=":     return K_EQUAL;
      "!":     return K_BANG;
      "<":     return K_LESS;
      ">":     return K_GREATER;
      default: return K_SLASH;
    endcase
  endfunction

endpackage

[rtl/slx_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_front - byte scanner
// Classifies one byte per cycle while accept is high; builds its token bundle.
// ----------------------------------------------------------------------------
module slx_front import slx_pkg::*; #(
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_source,
  output logic       push,
  output bundle_t    bundle
);

  localparam int CW = COUNT_WIDTH;
  localparam int PW = 8 * KEYWORD_MAX_LEN;

  typedef enum logic [2:0] {
    M_IDLE, M_WORD, M_NUM, M_NUMDOT, M_FRAC, M_CMT, M_OP
  } mode_t;

  mode_t         mode, mode_next;
  logic [7:0]    pend, pend_next;
  logic [PW-1:0] prefix, prefix_next;
  logic [CW-1:0] tstart, tstart_next;
  logic [CW-1:0] tlen, tlen_next;
  logic [CW-1:0] lcnt, lcnt_next;
  logic [CW-1:0] bpos, bpos_next;

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [15:0] clamp(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [5:0] wkind(input logic [PW-1:0] pre, input logic [CW-1:0] len);
    logic [3:0] l;
    l = (len > CW'(15)) ? 4'd15 : len[3:0];
    return kw_kind(64'(pre), l);
  endfunction

  function automatic tok_t mk(input logic [5:0] k, input logic [CW-1:0] s,
                              input logic [CW-1:0] l, input logic [CW-1:0] ln);
    tok_t t;
    t.kind  = k;
    t.start = clamp(s);
    t.len   = clamp(l);
    t.line  = clamp(ln);
    return t;
  endfunction

  always_comb begin
    logic       fall;
    logic [2:0] n;
    logic [7:0] c;
    fall        = 1'b0;
    n           = 3'd0;
    c           = char_code;
    bundle      = '0;
    mode_next   = mode;
    pend_next   = pend;
    prefix_next = prefix;
    tstart_next = tstart;
    tlen_next   = tlen;
    lcnt_next   = lcnt;
    bpos_next   = sat(bpos, CW'(1));

    case (mode)
      M_CMT: begin
        if (c == 8'h0A) begin
          lcnt_next = sat(lcnt, CW'(1));
          mode_next = M_IDLE;
        end
      end
      M_OP: begin
        if (pend == "/" && c == "/") begin
          mode_next = M_CMT;
        end else if (pend != "/" && c == "=") begin
          bundle.tok[n[1:0]] = mk(op_kind(pend) + 6'd1, tstart, CW'(2), lcnt);
          n = n + 3'd1;
          mode_next = M_IDLE;
        end else begin
          fall = 1'b1;
        end
      end
      M_WORD: begin
        if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) begin
          if (tlen < CW'(KEYWORD_MAX_LEN)) prefix_next = {prefix[PW-9:0], c};
          tlen_next = sat(tlen, CW'(1));
        end else begin
          fall = 1'b1;
        end
      end
      M_NUM: begin
        if (c inside {["0":"9"]}) tlen_next = sat(tlen, CW'(1));
        else if (c == ".")       mode_next = M_NUMDOT;
        else                     fall = 1'b1;
      end
      M_NUMDOT: begin
        if (c inside {["0":"9"]}) begin
          tlen_next = sat(tlen, CW'(2));
          mode_next = M_FRAC;
        end else begin
          fall = 1'b1;
        end
      end
      M_FRAC: begin
        if (c inside {["0":"9"]}) tlen_next = sat(tlen, CW'(1));
        else                     fall = 1'b1;
      end
      default: fall = 1'b1;
    endcase

    if (fall) begin
      // close whatever was open, then scan the byte from idle
      case (mode)
        M_WORD: begin
          bundle.tok[n[1:0]] = mk(wkind(prefix, tlen), tstart, tlen, lcnt);
          n = n + 3'd1;
        end
        M_NUM, M_FRAC: begin
          bundle.tok[n[1:0]] = mk(K_NUMBER, tstart, tlen, lcnt);
          n = n + 3'd1;
        end
        M_NUMDOT: begin
          bundle.tok[n[1:0]] = mk(K_NUMBER, tstart, tlen, lcnt);
          n = n + 3'd1;
          bundle.tok[n[1:0]] = mk(K_DOT, sat(tstart, tlen), CW'(1), lcnt);
          n = n + 3'd1;
        end
        M_OP: begin
          bundle.tok[n[1:0]] = mk(op_kind(pend), tstart, CW'(1), lcnt);
          n = n + 3'd1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
      case (c) inside
        8'h0A: lcnt_next = sat(lcnt, CW'(1));
        " ", 8'h0D, 8'h09: ;
        "(", ")", "{", "}", ",", ".", "-", "+", ";", "*": begin
          case (c)
            "(":     bundle.tok[n[1:0]] = mk(6'd0, bpos, CW'(1), lcnt);
            ")":     bundle.tok[n[1:0]] = mk(6'd1, bpos, CW'(1), lcnt);
            "{":     bundle.tok[n[1:0]] = mk(6'd2, bpos, CW'(1), lcnt);
            "}":     bundle.tok[n[1:0]] = mk(6'd3, bpos, CW'(1), lcnt);
            ",":     bundle.tok[n[1:0]] = mk(6'd4, bpos, CW'(1), lcnt);
            ".":     bundle.tok[n[1:0]] = mk(K_DOT, bpos, CW'(1), lcnt);
            "-":     bundle.tok[n[1:0]] = mk(6'd6, bpos, CW'(1), lcnt);
            "+":     bundle.tok[n[1:0]] = mk(6'd7, bpos, CW'(1), lcnt);
            ";":     bundle.tok[n[1:0]] = mk(6'd8, bpos, CW'(1), lcnt);
            default: bundle.tok[n[1:0]] = mk(6'd10, bpos, CW'(1), lcnt);
          endcase
          n = n + 3'd1;
        end
        "=", "!", "<", ">", "/": begin
          mode_next   = M_OP;
          pend_next   = c;
          tstart_next = bpos;
        end
        "\"": mode_next = M_CMT;
        ["0":"9"]: begin
          mode_next   = M_NUM;
          tstart_next = bpos;
          tlen_next   = CW'(1);
        end
        ["a":"z"], ["A":"Z"], "_": begin
          mode_next   = M_WORD;
          tstart_next = bpos;
          tlen_next   = CW'(1);
          prefix_next = PW'(c);
        end
        default: begin
          bundle.tok[n[1:0]] = mk(K_ERROR, bpos, CW'(1), lcnt);
          n = n + 3'd1;
        end
      endcase
    end

    if (end_of_source) begin
      case (mode_next)
        M_WORD: begin
          bundle.tok[n[1:0]] = mk(wkind(prefix_next, tlen_next), tstart_next, tlen_next,
                                  lcnt_next);
          n = n + 3'd1;
        end
        M_NUM, M_FRAC: begin
          bundle.tok[n[1:0]] = mk(K_NUMBER, tstart_next, tlen_next, lcnt_next);
          n = n + 3'd1;
        end
        M_NUMDOT: begin
          bundle.tok[n[1:0]] = mk(K_NUMBER, tstart_next, tlen_next, lcnt_next);
          n = n + 3'd1;
          bundle.tok[n[1:0]] = mk(K_DOT, sat(tstart_next, tlen_next), CW'(1), lcnt_next);
          n = n + 3'd1;
        end
        M_OP: begin
          bundle.tok[n[1:0]] = mk(op_kind(pend_next), tstart_next, CW'(1), lcnt_next);
          n = n + 3'd1;
        end
        default: ;
      endcase
      bundle.tok[n[1:0]] = mk(K_END, bpos_next, '0, lcnt_next);
      n = n + 3'd1;
      mode_next   = M_IDLE;
      pend_next   = '0;
      prefix_next = '0;
      tstart_next = '0;
      tlen_next   = '0;
      lcnt_next   = '0;
      bpos_next   = '0;
    end
    bundle.cnt = n;
  end

  assign push = accept && (bundle.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pend   <= '0;
      prefix <= '0;
      tstart <= '0;
      tlen   <= '0;
      lcnt   <= '0;
      bpos   <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      pend   <= pend_next;
      prefix <= prefix_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      lcnt   <= lcnt_next;
      bpos   <= bpos_next;
    end
  end

endmodule

[rtl/slx_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_queue - two-entry bundle queue
// Decouples the scanner from the token serializer.
// ----------------------------------------------------------------------------
module slx_queue import slx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  input  logic    pop,
  output logic    nonempty,
  output logic    full,
  output bundle_t head
);

  bundle_t    mem [2];
  logic       wr, rd;
  logic [1:0] count;

  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign head     = mem[rd];

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= 1'b0;
      rd    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop)  rd <= ~rd;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/slx_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_back - token serializer
// Sends the tokens of each bundle one beat at a time through an output register.
// ----------------------------------------------------------------------------
module slx_back import slx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] lexeme_length,
  output logic [15:0] line_number,
  output logic        last_in_run
);

  logic [1:0] idx;
  logic       load, last;
  tok_t       cur;

  assign load = q_valid && (!out_valid || out_ready);
  assign last = ((3'(idx) + 3'd1) == head.cnt);
  assign pop  = load && last;
  assign cur  = head.tok[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load) idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind    <= cur.kind;
      start_offset  <= cur.start;
      lexeme_length <= cur.len;
      line_number   <= cur.line;
      last_in_run   <= last;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (3'(idx) < head.cnt)) else $error("token index past bundle");
  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (head.cnt != 3'd0)) else $error("empty bundle queued");
  a_pop_rewinds: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0)) else $error("index not rewound after bundle");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid) else $error("loaded beat not presented");
`endif

endmodule

[rtl/script_lexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_lexer - streaming Lox scanner
// Source bytes in, tokens (kind, offset, length, line) out.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | char_code, end_of_source
//  out     | out_valid/out_ready | token_kind, start_offset, lexeme_length,
//          |                     | line_number, last_in_run
//
// One source byte is taken per cycle while the queue has a free slot; its
// tokens (zero to four) leave one beat per cycle while out_ready is high.
// Scanner state updates in the cycle a byte is taken; its tokens pass through
// the queue, then the output register. A two-bundle queue lets input flow while
// the output stalls, until full. Synchronous reset clears all control state.
// ----------------------------------------------------------------------------
module script_lexer import slx_pkg::*; #(
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
  parameter int KEYWORD_MAX_LEN = KW_MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] lexeme_length,
  output logic [15:0] line_number,
  output logic        last_in_run
);

  logic    push, pop, q_valid, q_full;
  bundle_t bundle, head;

  // front accepts whenever the queue has a free slot
  assign in_ready = !q_full;

  slx_front #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_valid && in_ready),
    .char_code    (char_code),
    .end_of_source(end_of_source),
    .push         (push),
    .bundle       (bundle)
  );

  slx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   (bundle),
    .pop     (pop),
    .nonempty(q_valid),
    .full    (q_full),
    .head    (head)
  );

  slx_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .lexeme_length(lexeme_length),
    .line_number  (line_number),
    .last_in_run  (last_in_run)
  );

endmodule
